>>> rtl/hfi_pkg.sv
package hfi_pkg;

  localparam int BUCKETS  = 1024;
  localparam int CAPACITY = 4096;
  localparam int KEY_W    = 64;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LINK_W   = IDX_W + 1;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = QPTR_W + 1;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [BKT_W-1:0]  bkt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  localparam link_t LINK_END = link_t'(CAPACITY);

  typedef struct packed {
    key_t key;
    bkt_t bkt;
  } req_t;

  typedef struct packed {
    key_t  key;
    link_t link;
  } entry_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } qhead_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ENTRY
  } walk_state_t;

  function automatic bkt_t bucket_of(key_t k);
    logic [31:0] folded;
    folded = k[31:0] ^ k[KEY_W-1:32];
    return folded[BKT_W-1:0];
  endfunction

endpackage

>>> rtl/hfi_front.sv
module hfi_front import hfi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  key_t key,
  output logic q_push,
  output req_t q_req,
  input  logic q_full
);

  logic fv;
  req_t freq;

  assign q_push = fv && !q_full;
  assign full   = fv && q_full;
  assign q_req  = freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (push && !full) begin
      fv <= 1'b1;
    end else if (q_push) begin
      fv <= 1'b0;
    end
  end

  // classify: fold the key and pick its bucket
  always_ff @(posedge clk) begin
    if (push && !full) begin
      freq.key <= key;
      freq.bkt <= bucket_of(key);
    end
  end

endmodule

>>> rtl/hfi_queue.sv
module hfi_queue import hfi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_push,
  input  req_t   q_req,
  output logic   q_full,
  input  logic   q_pop,
  output qhead_t q_head
);

  req_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign q_full       = count == QCNT_W'(QDEPTH);
  assign q_head.valid = count != '0;
  assign q_head.req   = slots[rd_ptr];
  assign do_push      = q_push && !q_full;
  assign do_pop       = q_pop && q_head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_req;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_pop_counts: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

>>> rtl/hfi_back.sv
module hfi_back import hfi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qhead_t q_head,
  output logic   q_pop,
  output logic   empty,
  input  logic   pop,
  output idx_t   entry_index,
  output logic   inserted,
  output logic   pool_full
);

  walk_state_t state;
  walk_state_t state_next;

  link_t  bucket_head [BUCKETS];
  entry_t entries     [CAPACITY];

  link_t  head_q;
  entry_t entry_q;
  link_t  next_free;

  key_t key_r;
  bkt_t bkt_r;
  idx_t cur;
  idx_t hd;
  logic first;

  logic out_valid;
  logic out_free;

  logic head_re;
  logic ent_re;
  idx_t ent_ra;
  logic ld_head;
  logic ld_cur;
  logic done;
  logic hit;
  logic head_ok;
  logic fire;
  logic no_room;
  logic ins_we;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign fire     = done && out_free;
  assign no_room  = next_free == LINK_END;
  assign ins_we   = fire && !hit && !no_room;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_head.valid) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (!done) begin
          state_next = ST_ENTRY;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_ENTRY: begin
        if (done && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    head_re = 1'b0;
    ent_re  = 1'b0;
    ent_ra  = '0;
    ld_head = 1'b0;
    ld_cur  = 1'b0;
    done    = 1'b0;
    hit     = 1'b0;
    head_ok = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop   = 1'b1;
          head_re = 1'b1;
        end
      end
      ST_HEAD: begin
        // a head is genuine only if it names a used entry of this bucket
        if (head_q < next_free) begin
          ent_re  = 1'b1;
          ent_ra  = head_q[IDX_W-1:0];
          ld_head = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      ST_ENTRY: begin
        priority if (first && bucket_of(entry_q.key) != bkt_r) begin
          done = 1'b1;
        end else if (entry_q.key == key_r) begin
          done = 1'b1;
          hit  = 1'b1;
        end else if (entry_q.link < LINK_END) begin
          ent_re = 1'b1;
          ent_ra = entry_q.link[IDX_W-1:0];
          ld_cur = 1'b1;
        end else begin
          done    = 1'b1;
          head_ok = 1'b1;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_free <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ins_we) begin
        next_free <= next_free + 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r <= q_head.req.key;
      bkt_r <= q_head.req.bkt;
    end
    if (ld_head) begin
      hd    <= head_q[IDX_W-1:0];
      cur   <= head_q[IDX_W-1:0];
      first <= 1'b1;
    end else if (ld_cur) begin
      cur   <= entry_q.link[IDX_W-1:0];
      first <= 1'b0;
    end
    if (fire) begin
      entry_index <= hit ? cur : (no_room ? '0 : next_free[IDX_W-1:0]);
      inserted    <= !hit && !no_room;
      pool_full   <= !hit && no_room;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      bucket_head[bkt_r] <= next_free;
    end
    if (head_re) begin
      head_q <= bucket_head[q_head.req.bkt];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      entries[next_free[IDX_W-1:0]] <= '{key: key_r, link: head_ok ? {1'b0, hd} : LINK_END};
    end
    if (ent_re) begin
      entry_q <= entries[ent_ra];
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= LINK_END)
    else $error("pool count beyond capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    ins_we |-> next_free < LINK_END)
    else $error("insert with pool exhausted");

  a_insert_step: assert property (@(posedge clk) disable iff (rst)
    ins_we |=> next_free == $past(next_free) + 1'b1)
    else $error("pool count did not advance on insert");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    fire |-> (!out_valid || pop))
    else $error("result overwrote a waiting item");

  a_walk_down: assert property (@(posedge clk) disable iff (rst)
    ld_cur |-> entry_q.link[IDX_W-1:0] < cur)
    else $error("chain link does not point to an older entry");

endmodule

>>> rtl/hash_find_or_insert.sv
// channel   direction  handshake         fields
// input     in         push / full       key[63:0]
// result    out        pop / empty       entry_index[11:0], inserted, pool_full
//
// An item is registered in the classify stage, then waits in a four-deep queue.
// The walk reads one bucket head, then visits the chain with one entry read per cycle
// through the single entry memory port.
// Reset is synchronous; no clearing pass: a bucket head counts only if it names a
// used entry whose key falls in that bucket.
// A waiting result holds the walk at its last step; new items still fill the queue.
module hash_find_or_insert import hfi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  key_t key,
  output logic empty,
  input  logic pop,
  output idx_t entry_index,
  output logic inserted,
  output logic pool_full
);

  logic   q_push;
  req_t   q_req;
  logic   q_full;
  logic   q_pop;
  qhead_t q_head;

  hfi_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .key    (key),
    .q_push (q_push),
    .q_req  (q_req),
    .q_full (q_full)
  );

  hfi_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_req  (q_req),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  hfi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .entry_index (entry_index),
    .inserted    (inserted),
    .pool_full   (pool_full)
  );

endmodule

>>> test/hfi_lookup_checker.sv
module hfi_lookup_checker import hfi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  key_t key,
  input  logic empty,
  input  logic pop,
  input  idx_t entry_index,
  input  logic inserted,
  input  logic pool_full,
  output int   errors,
  output int   pending,
  output int   found_cnt,
  output int   new_cnt,
  output int   full_cnt
);

  typedef struct packed {
    idx_t index;
    logic is_new;
    logic no_room;
  } lookup_res_t;

  link_t       head_of [BUCKETS];
  key_t        key_of  [CAPACITY];
  link_t       link_of [CAPACITY];
  int unsigned used;
  lookup_res_t lookups_due [$];

  function automatic lookup_res_t lookup_or_insert(key_t k);
    logic [31:0] folded;
    bkt_t        bkt;
    int unsigned steps;
    link_t       cur;
    lookup_res_t res;
    folded = k[31:0] ^ k[63:32];
    bkt    = bkt_t'(folded % BUCKETS);
    cur    = head_of[bkt];
    steps  = 0;
    res    = '0;
    while (cur < CAPACITY && steps < CAPACITY) begin
      if (key_of[cur[IDX_W-1:0]] == k) begin
        res.index = idx_t'(cur);
        return res;
      end
      cur = link_of[cur[IDX_W-1:0]];
      steps++;
    end
    if (used >= CAPACITY) begin
      res.no_room = 1'b1;
      return res;
    end
    key_of[idx_t'(used)]  = k;
    link_of[idx_t'(used)] = head_of[bkt];
    head_of[bkt]          = link_t'(used);
    res.index             = idx_t'(used);
    res.is_new            = 1'b1;
    used++;
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_res_t got;
    lookup_res_t want;
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) head_of[b] = LINK_END;
      for (int e = 0; e < CAPACITY; e++) begin
        key_of[e]  = '0;
        link_of[e] = LINK_END;
      end
      used = 0;
      lookups_due.delete();
    end else begin
      if (pop && !empty) begin
        got = {entry_index, inserted, pool_full};
        if (lookups_due.size() == 0) begin
          errors++;
          $display("%0t unexpected item: entry_index %0d inserted %0b pool_full %0b",
                   $time, got.index, got.is_new, got.no_room);
        end else begin
          want = lookups_due.pop_front();
          if (got.index !== want.index) begin
            errors++;
            $display("%0t entry_index: expected %0d, actual %0d",
                     $time, want.index, got.index);
          end
          if (got.is_new !== want.is_new) begin
            errors++;
            $display("%0t inserted: expected %0b, actual %0b",
                     $time, want.is_new, got.is_new);
          end
          if (got.no_room !== want.no_room) begin
            errors++;
            $display("%0t pool_full: expected %0b, actual %0b",
                     $time, want.no_room, got.no_room);
          end
          if (want.no_room) full_cnt++;
          else if (want.is_new) new_cnt++;
          else found_cnt++;
        end
      end
      if (push && !full) lookups_due.push_back(lookup_or_insert(key));
    end
    pending <= lookups_due.size();
  end

endmodule

>>> test/tb_hash_find_or_insert.sv
module tb_hash_find_or_insert;
  import hfi_pkg::*;

  localparam int LIMIT        = 2_000_000;
  localparam int RANDOM_ITEMS = 1600;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  key_t key   = '0;
  logic full;
  logic empty;
  idx_t entry_index;
  logic inserted;
  logic pool_full;

  int errors;
  int pending;
  int found_cnt;
  int new_cnt;
  int full_cnt;
  int cycles  = 0;
  int offered = 0;
  int taken   = 0;
  int tx_run  = 0;
  int rx_run  = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  key_t stored_q [$];
  bit   seen [key_t];
  bkt_t hot [4];

  key_t directed_keys [$] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0001_0000_0001, 64'h8000_0000_8000_0000,
    64'h0000_0000_0000_0400, 64'h8000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0001_0000_0001,
    64'h0000_0000_0000_03FF, 64'hFFFF_FFFF_0000_0000,
    64'h0000_0001_0000_0000, 64'h0123_4567_89AB_CDEF,
    64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF,
    64'h8000_0000_8000_0000, 64'hFFFF_FFFF_0000_0000
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hash_find_or_insert u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .key         (key),
    .empty       (empty),
    .pop         (pop),
    .entry_index (entry_index),
    .inserted    (inserted),
    .pool_full   (pool_full)
  );

  hfi_lookup_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .key         (key),
    .empty       (empty),
    .pop         (pop),
    .entry_index (entry_index),
    .inserted    (inserted),
    .pool_full   (pool_full),
    .errors      (errors),
    .pending     (pending),
    .found_cnt   (found_cnt),
    .new_cnt     (new_cnt),
    .full_cnt    (full_cnt)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d items outstanding", $time, cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_gap(inout int run, inout bit calm);
    if (run == 0) begin
      run  = $urandom_range(10, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    do k = {$urandom, $urandom}; while (seen.exists(k));
    return k;
  endfunction

  task automatic send(key_t k);
    int gap;
    gap = draw_gap(tx_run, tx_calm);
    if (!seen.exists(k) && stored_q.size() < CAPACITY) begin
      seen[k] = 1'b1;
      stored_q.push_back(k);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    key  <= k;
    @(posedge clk);
    while (full) @(posedge clk);
    offered++;
  endtask

  // hold off twice for a long stretch so the block backs up and raises full
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = draw_gap(rx_run, rx_calm);
      if (taken == 150 || taken == 900) gap = 500;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      taken++;
    end
  end

  initial begin
    key_t        k;
    int          pick;
    logic [31:0] hi;
    logic [31:0] fold;
    for (int i = 0; i < 4; i++) hot[i] = bkt_t'($urandom_range(0, BUCKETS - 1));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_keys[i]) send(directed_keys[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && stored_q.size() > 0) begin
        k = stored_q[$urandom_range(0, stored_q.size() - 1)];
      end else if (pick < 60) begin
        hi   = $urandom;
        fold = $urandom;
        fold[BKT_W-1:0] = hot[$urandom_range(0, 3)];
        k = {hi, hi ^ fold};
      end else if (pick < 70) begin
        k = key_t'(1) << $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 1) k = ~k;
      end else begin
        k = {$urandom, $urandom};
      end
      send(k);
    end

    // mix absent keys with stored ones
    for (int n = 0; n < 40; n++) begin
      if (n % 2 == 0) send(fresh_key());
      else send(stored_q[$urandom_range(0, stored_q.size() - 1)]);
    end
    push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Offered %0d keys, %0d of them distinct, to a %0d-entry pool",
             offered, stored_q.size(), CAPACITY);
    $display("Checked %0d found, %0d inserted, %0d refused on a full pool",
             found_cnt, new_cnt, full_cnt);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hfi_pkg.sv
rtl/hfi_front.sv
rtl/hfi_queue.sv
rtl/hfi_back.sv
rtl/hash_find_or_insert.sv
test/hfi_lookup_checker.sv
test/tb_hash_find_or_insert.sv
